// File: sv/uhc_pkg.sv
// ----------------------------------------------------------------------------
// URL host classifier package
// Shared character constants, suffix codes and result status codes.
// ----------------------------------------------------------------------------
package uhc_pkg;

  localparam logic [7:0] PREFIX_LEN = 8'd7;

  localparam logic [7:0] PREFIX_TEXT [0:6] = '{
    8'h68, 8'h74, 8'h74, 8'h70, 8'h3A, 8'h2F, 8'h2F
  };

  localparam logic [31:0] SUFFIX_GOV = 32'h2E67_6F76;
  localparam logic [31:0] SUFFIX_ORG = 32'h2E6F_7267;

  localparam logic [7:0] UPPER_FIRST = 8'd65;
  localparam logic [7:0] UPPER_LAST  = 8'd90;
  localparam logic [7:0] DIGIT_FIRST = 8'd48;
  localparam logic [7:0] DIGIT_LAST  = 8'd57;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [7:0] CHAR_DOT    = 8'h2E;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_COLON  = 8'h3A;

  localparam logic [2:0] OCTET_COUNT = 3'd4;
  localparam logic [7:0] COUNT_MAX   = 8'd255;
  localparam logic [7:0] SHORT_NAME  = 8'd4;

  typedef enum logic [2:0] {
    STATUS_BAD_PREFIX = 3'd0,
    STATUS_IPV4       = 3'd1,
    STATUS_GOV        = 3'd2,
    STATUS_ORG        = 3'd3,
    STATUS_OTHER      = 3'd4
  } status_t;

endpackage

// File: sv/url_host_classifier.sv
// ----------------------------------------------------------------------------
// URL host classifier
// Streams a URL one character per transfer and classifies its host.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (char_in, is_last) carries one URL character per transfer;
//   is_last marks the final character. The output channel carries one result
//   (status, ipv4_address, octet_overflow, host_length) per URL, on the
//   transfer that follows the character marked last.
//   Throughput: one character per cycle. The per-character work (case fold,
//   prefix compare, multiply-by-ten octet accumulate, suffix shift) sits
//   between the input register and the parse state / result register.
//   The result is registered when the last character leaves the input register.
//   Reset clears the parse state and both valid flags; the next character
//   starts a new URL. After each result the parse state returns to reset.
//   Receiver stall: the result register holds; characters that give no
//   result keep flowing, and the input stalls only when a final character
//   meets a full, stalled result register.
// ----------------------------------------------------------------------------
module url_host_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_in,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [31:0] ipv4_address,
  output logic        octet_overflow,
  output logic [7:0]  host_length
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       out_free;
  logic       s1_go;

  logic [7:0]  char_position, char_position_next;
  logic        prefix_good, prefix_good_next;
  logic        host_ended, host_ended_next;
  logic        host_numeric, host_numeric_next;
  logic [2:0]  octet_index, octet_index_next;
  logic [7:0]  octet_accum, octet_accum_next;
  logic        overflow_seen, overflow_seen_next;
  logic [31:0] address_acc, address_acc_next;
  logic [31:0] tail_chars, tail_chars_next;
  logic [7:0]  host_count, host_count_next;

  logic [7:0]         c;
  logic [11:0]        wide_acc;
  logic [11:0]        digit_sum;
  uhc_pkg::status_t   res_status;
  logic [31:0]        res_addr;
  logic               res_ovf;
  logic [7:0]         res_len;

  function automatic logic [31:0] place_octet(input logic [31:0] acc,
                                              input logic [2:0]  idx,
                                              input logic [7:0]  val);
    logic [31:0] r;
    r = acc;
    if (idx < uhc_pkg::OCTET_COUNT) begin
      case (idx[1:0])
        2'd0:    r[31:24] = r[31:24] | val;
        2'd1:    r[23:16] = r[23:16] | val;
        2'd2:    r[15:8]  = r[15:8]  | val;
        default: r[7:0]   = r[7:0]   | val;
      endcase
    end
    return r;
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!s1_last || out_free);
  assign in_stall = s1_valid && !s1_go;

  always_comb begin
    c = s1_char;
    if (s1_char inside {[uhc_pkg::UPPER_FIRST:uhc_pkg::UPPER_LAST]}) begin
      c = s1_char + uhc_pkg::CASE_OFFSET;
    end

    char_position_next = char_position;
    prefix_good_next   = prefix_good;
    host_ended_next    = host_ended;
    host_numeric_next  = host_numeric;
    octet_index_next   = octet_index;
    octet_accum_next   = octet_accum;
    overflow_seen_next = overflow_seen;
    address_acc_next   = address_acc;
    tail_chars_next    = tail_chars;
    host_count_next    = host_count;

    wide_acc  = {4'b0, octet_accum};
    digit_sum = (wide_acc << 3) + (wide_acc << 1) + {8'b0, c[3:0]};

    if (char_position < uhc_pkg::PREFIX_LEN) begin
      if (c != uhc_pkg::PREFIX_TEXT[char_position[2:0]]) begin
        prefix_good_next = 1'b0;
      end
    end else if (!host_ended) begin
      if (c == uhc_pkg::CHAR_SLASH || c == uhc_pkg::CHAR_COLON) begin
        host_ended_next = 1'b1;
      end else begin
        if (host_count < uhc_pkg::COUNT_MAX) begin
          host_count_next = host_count + 8'd1;
        end
        tail_chars_next = {tail_chars[23:0], c};
        if (c inside {[uhc_pkg::DIGIT_FIRST:uhc_pkg::DIGIT_LAST]}) begin
          if (octet_index < uhc_pkg::OCTET_COUNT) begin
            if (digit_sum > 12'd255) begin
              octet_accum_next   = 8'd255;
              overflow_seen_next = 1'b1;
            end else begin
              octet_accum_next = digit_sum[7:0];
            end
          end
        end else if (c == uhc_pkg::CHAR_DOT) begin
          if (octet_index < uhc_pkg::OCTET_COUNT) begin
            address_acc_next = place_octet(address_acc, octet_index, octet_accum);
            octet_index_next = octet_index + 3'd1;
          end
          octet_accum_next = 8'd0;
        end else begin
          host_numeric_next = 1'b0;
        end
      end
    end
    if (char_position < uhc_pkg::COUNT_MAX) begin
      char_position_next = char_position + 8'd1;
    end

    res_addr = 32'd0;
    res_ovf  = 1'b0;
    res_len  = 8'd0;
    if (!prefix_good_next || char_position_next < uhc_pkg::PREFIX_LEN) begin
      res_status = uhc_pkg::STATUS_BAD_PREFIX;
    end else begin
      res_len = host_count_next;
      if (host_numeric_next) begin
        res_status = uhc_pkg::STATUS_IPV4;
        res_addr   = place_octet(address_acc_next, octet_index_next, octet_accum_next);
        res_ovf    = overflow_seen_next;
      end else if (host_count_next >= uhc_pkg::SHORT_NAME &&
                   tail_chars_next == uhc_pkg::SUFFIX_GOV) begin
        res_status = uhc_pkg::STATUS_GOV;
      end else if (host_count_next >= uhc_pkg::SHORT_NAME &&
                   tail_chars_next == uhc_pkg::SUFFIX_ORG) begin
        res_status = uhc_pkg::STATUS_ORG;
      end else begin
        res_status = uhc_pkg::STATUS_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      s1_char <= char_in;
      s1_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      char_position <= 8'd0;
      prefix_good   <= 1'b1;
      host_ended    <= 1'b0;
      host_numeric  <= 1'b1;
      octet_index   <= 3'd0;
      octet_accum   <= 8'd0;
      overflow_seen <= 1'b0;
      address_acc   <= 32'd0;
      tail_chars    <= 32'd0;
      host_count    <= 8'd0;
    end else if (s1_go) begin
      char_position <= char_position_next;
      prefix_good   <= prefix_good_next;
      host_ended    <= host_ended_next;
      host_numeric  <= host_numeric_next;
      octet_index   <= octet_index_next;
      octet_accum   <= octet_accum_next;
      overflow_seen <= overflow_seen_next;
      address_acc   <= address_acc_next;
      tail_chars    <= tail_chars_next;
      host_count    <= host_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && s1_last;
    end
    if (out_free && s1_go && s1_last) begin
      status         <= res_status;
      ipv4_address   <= res_addr;
      octet_overflow <= res_ovf;
      host_length    <= res_len;
    end
  end

endmodule

// File: sv/uhc_checker.sv
// ----------------------------------------------------------------------------
// URL host classifier checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module uhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  char_in,
  input logic        is_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [31:0] ipv4_address,
  input logic        octet_overflow,
  input logic [7:0]  host_length
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(ipv4_address) && $stable(octet_overflow) && $stable(host_length))
    else $error("stalled result changed");

  // hold a stalled input transfer
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(char_in) && $stable(is_last))
    else $error("stalled input changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == uhc_pkg::STATUS_BAD_PREFIX |->
      ipv4_address == 32'd0 && !octet_overflow && host_length == 8'd0)
    else $error("bad prefix result carries host data");

  a_name_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != uhc_pkg::STATUS_IPV4 |->
      ipv4_address == 32'd0 && !octet_overflow)
    else $error("non-address result carries address data");

  a_suffix_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == uhc_pkg::STATUS_GOV || status == uhc_pkg::STATUS_ORG) |->
      host_length >= uhc_pkg::SHORT_NAME)
    else $error("suffix match on short host");

endmodule

bind url_host_classifier uhc_checker u_uhc_checker (.*);
